/* rtl/bole_pkg.sv */
// Package of the bounded ordered list engine: request and status codes, FSM states, defaults.
package bole_pkg;

	localparam int CAPACITY_DEF   = 64;
	localparam int DATA_WIDTH_DEF = 32;

	typedef enum logic [2:0] {
		REQ_INS_FRONT = 3'd0,
		REQ_INS_BACK  = 3'd1,
		REQ_REM_FRONT = 3'd2,
		REQ_REM_BACK  = 3'd3,
		REQ_REM_AT    = 3'd4,
		REQ_READ_AT   = 3'd5,
		REQ_FIND      = 3'd6
	} req_t;

	typedef enum logic [2:0] {
		STS_OK       = 3'd0,
		STS_FULL     = 3'd1,
		STS_EMPTY    = 3'd2,
		STS_BADPOS   = 3'd3,
		STS_NOTFOUND = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_WALK = 2'b10
	} state_t;

endpackage

/* rtl/bounded_ordered_list_engine.sv */
// Bounded ordered list engine: a ring of CAPACITY words in one RAM with head slot and count.
// Inserts and rejected requests give their result in the cycle after start; remove front/back
// and read at issue one RAM read, handle its registered read data, then register the result;
// find and remove at walk the RAM one read per cycle through the single RAM read port.
// Results are one-cycle done beats and cannot be stalled; arst_n empties the list at once.
module bounded_ordered_list_engine #(
	parameter int CAPACITY   = bole_pkg::CAPACITY_DEF,
	parameter int DATA_WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic [2:0]  req_type,
	input  logic [31:0] value,
	input  logic [6:0]  position,
	output logic        done,
	output logic [2:0]  status,
	output logic [31:0] data,
	output logic [5:0]  found_position,
	output logic [6:0]  count
);

	localparam int SW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int PW = (CW > 7) ? CW : 7;
	localparam int DW = DATA_WIDTH;

	function automatic logic [SW-1:0] slot_of(input logic [SW-1:0] h, input logic [CW-1:0] i);
		logic [CW:0] s;
		s = {{(CW + 1 - SW){1'b0}}, h} + {1'b0, i};
		if (s >= (CW + 1)'(CAPACITY)) begin
			s = s - (CW + 1)'(CAPACITY);
		end
		return s[SW-1:0];
	endfunction

	function automatic logic [31:0] to_word(input logic [DW-1:0] d);
		logic [DW+31:0] x;
		x = {32'b0, d};
		return x[31:0];
	endfunction

	bole_pkg::state_t  state_q;
	bole_pkg::req_t    op_q;
	bole_pkg::status_t status_q;
	logic [SW-1:0]     head_q;
	logic [CW-1:0]     cnt_q;
	logic [CW-1:0]     rd_idx_q;
	logic [CW-1:0]     last_q;
	logic [CW-1:0]     pos_q;
	logic [DW-1:0]     key_q;
	logic [DW-1:0]     hold_q;
	logic [SW-1:0]     prev_slot_q;
	logic              done_q;
	logic [31:0]       data_q;
	logic [5:0]        found_q;
	logic              pend_s1;
	logic [CW-1:0]     idx_s1;
	logic [SW-1:0]     slot_s1;

	logic              accept;
	bole_pkg::req_t    req;
	logic [DW+31:0]    val_x;
	logic [DW-1:0]     val;
	logic [CW-1:0]     pos_c;
	logic [CW-1:0]     cnt_m1;
	logic              empty;
	logic              full;
	logic              pos_ok;
	logic [SW-1:0]     head_dec;
	logic [SW-1:0]     head_inc;
	logic              imm_done;
	bole_pkg::status_t imm_st;
	logic              walk_go;
	logic [CW-1:0]     start_idx;
	logic [CW-1:0]     last_idx;
	logic              ins_ok;
	logic              issue;
	logic [SW-1:0]     raddr;
	logic [DW-1:0]     rdata;
	logic              is_last;
	logic              hit;
	logic              finish;
	logic              shift_we;
	logic              we;
	logic [SW-1:0]     waddr;
	logic [DW-1:0]     wdata;
	logic [CW+5:0]     found_x;
	logic [CW+6:0]     count_x;

	assign accept   = start && (state_q == bole_pkg::ST_IDLE);
	assign busy     = (state_q != bole_pkg::ST_IDLE);
	assign req      = bole_pkg::req_t'(req_type);
	assign val_x    = {{DW{1'b0}}, value};
	assign val      = val_x[DW-1:0];
	assign pos_c    = CW'(position);
	assign cnt_m1   = cnt_q - 1'b1;
	assign empty    = (cnt_q == '0);
	assign full     = (cnt_q >= CW'(CAPACITY));
	assign pos_ok   = (PW'(position) < PW'(cnt_q));
	assign head_dec = (head_q == '0) ? SW'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc = (head_q == SW'(CAPACITY - 1)) ? '0 : head_q + 1'b1;

	// Decode of a new request: either answered at once or handed to the RAM walk.
	always_comb begin
		imm_done  = 1'b0;
		imm_st    = bole_pkg::STS_OK;
		walk_go   = 1'b0;
		start_idx = '0;
		last_idx  = '0;
		ins_ok    = 1'b0;
		case (req)
			bole_pkg::REQ_INS_FRONT, bole_pkg::REQ_INS_BACK: begin
				imm_done = 1'b1;
				if (full) begin
					imm_st = bole_pkg::STS_FULL;
				end else begin
					ins_ok = 1'b1;
				end
			end
			bole_pkg::REQ_REM_FRONT, bole_pkg::REQ_REM_BACK: begin
				if (empty) begin
					imm_done = 1'b1;
					imm_st   = bole_pkg::STS_EMPTY;
				end else begin
					walk_go   = 1'b1;
					start_idx = (req == bole_pkg::REQ_REM_BACK) ? cnt_m1 : '0;
					last_idx  = start_idx;
				end
			end
			bole_pkg::REQ_REM_AT, bole_pkg::REQ_READ_AT: begin
				if (empty) begin
					imm_done = 1'b1;
					imm_st   = bole_pkg::STS_EMPTY;
				end else if (!pos_ok) begin
					imm_done = 1'b1;
					imm_st   = bole_pkg::STS_BADPOS;
				end else begin
					walk_go   = 1'b1;
					start_idx = pos_c;
					last_idx  = (req == bole_pkg::REQ_REM_AT) ? cnt_m1 : pos_c;
				end
			end
			bole_pkg::REQ_FIND: begin
				if (empty) begin
					imm_done = 1'b1;
					imm_st   = bole_pkg::STS_EMPTY;
				end else begin
					walk_go  = 1'b1;
					last_idx = cnt_m1;
				end
			end
			default: begin
				imm_done = 1'b1;
			end
		endcase
	end

	// Walk: one read issued per cycle, its data handled in the following cycle.
	assign issue    = (state_q == bole_pkg::ST_WALK) && (rd_idx_q <= last_q);
	assign raddr    = slot_of(head_q, rd_idx_q);
	assign is_last  = (idx_s1 == last_q);
	assign hit      = (rdata == key_q);
	assign finish   = pend_s1 && (is_last || ((op_q == bole_pkg::REQ_FIND) && hit));
	// Each word behind the removed one moves one slot toward the front.
	assign shift_we = pend_s1 && (op_q == bole_pkg::REQ_REM_AT) && (idx_s1 != pos_q);

	always_comb begin
		if (accept && ins_ok) begin
			we    = 1'b1;
			waddr = (req == bole_pkg::REQ_INS_FRONT) ? head_dec : slot_of(head_q, cnt_q);
			wdata = val;
		end else begin
			we    = shift_we;
			waddr = prev_slot_q;
			wdata = rdata;
		end
	end

	bole_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(DW)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= bole_pkg::ST_IDLE;
			head_q   <= '0;
			cnt_q    <= '0;
			rd_idx_q <= '0;
			pend_s1  <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			done_q  <= 1'b0;
			pend_s1 <= issue && !finish;
			if (issue) begin
				rd_idx_q <= rd_idx_q + 1'b1;
			end
			if (accept) begin
				done_q <= imm_done;
				if (ins_ok) begin
					cnt_q <= cnt_q + 1'b1;
					if (req == bole_pkg::REQ_INS_FRONT) begin
						head_q <= head_dec;
					end
				end
				if (walk_go) begin
					state_q  <= bole_pkg::ST_WALK;
					rd_idx_q <= start_idx;
				end
			end
			if (finish) begin
				state_q <= bole_pkg::ST_IDLE;
				done_q  <= 1'b1;
				case (op_q)
					bole_pkg::REQ_REM_FRONT: begin
						head_q <= head_inc;
						cnt_q  <= cnt_m1;
					end
					bole_pkg::REQ_REM_BACK, bole_pkg::REQ_REM_AT: begin
						cnt_q <= cnt_m1;
					end
					default: begin
					end
				endcase
			end
		end
	end

	assign found_x = {6'b0, idx_s1};

	always_ff @(posedge clk) begin
		idx_s1  <= rd_idx_q;
		slot_s1 <= raddr;
		if (accept) begin
			op_q     <= req;
			key_q    <= val;
			pos_q    <= pos_c;
			last_q   <= last_idx;
			status_q <= imm_st;
			data_q   <= '0;
			found_q  <= '0;
		end
		if (pend_s1) begin
			prev_slot_q <= slot_s1;
			if (idx_s1 == pos_q) begin
				hold_q <= rdata;
			end
		end
		if (finish) begin
			if (op_q == bole_pkg::REQ_FIND) begin
				status_q <= hit ? bole_pkg::STS_OK : bole_pkg::STS_NOTFOUND;
				data_q   <= '0;
				found_q  <= hit ? found_x[5:0] : '0;
			end else begin
				status_q <= bole_pkg::STS_OK;
				found_q  <= '0;
				if ((op_q == bole_pkg::REQ_REM_AT) && (idx_s1 != pos_q)) begin
					data_q <= to_word(hold_q);
				end else begin
					data_q <= to_word(rdata);
				end
			end
		end
	end

	assign count_x        = {7'b0, cnt_q};
	assign done           = done_q;
	assign status         = status_q;
	assign data           = data_q;
	assign found_position = found_q;
	assign count          = count_x[6:0];

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result beat while the walk is still running");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(CAPACITY))
		else $error("entry count above capacity");

	a_pend_walk: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> (state_q == bole_pkg::ST_WALK))
		else $error("read data pending outside the walk");

	a_accept_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && !imm_done) |=> busy)
		else $error("walking request did not enter the walk");

endmodule

/* rtl/bole_ram.sv */
// Simple dual-port entry memory: one write port, one read port with registered read data.
module bole_ram #(
	parameter int DEPTH = bole_pkg::CAPACITY_DEF,
	parameter int WIDTH = bole_pkg::DATA_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

/* sim/bounded_ordered_list_engine_tb.sv */
// Testbench of the bounded ordered list engine: directed and random list requests checked against a behavioral list.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_tb;
	import bole_pkg::*;

	localparam int CAP = CAPACITY_DEF;
	localparam logic [2:0] REQ_UNUSED = 3'd7;
	localparam int RANDOM_ITEMS = 1500;
	localparam int MAX_REPORTS = 10;
	localparam int TAIL_CYCLES = 80;

	typedef enum int {MIX_GROW, MIX_SHRINK, MIX_MIXED, MIX_FILL} mix_t;

	typedef struct packed {
		logic        drain;
		logic [2:0]  req;
		logic [31:0] val;
		logic [6:0]  pos;
	} list_req_t;

	typedef struct packed {
		status_t     sts;
		logic [31:0] word;
		logic [5:0]  fpos;
		logic [6:0]  cnt;
	} list_rsp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        start = 1'b0;
	logic [2:0]  req_type = '0;
	logic [31:0] value = '0;
	logic [6:0]  position = '0;
	logic        busy;
	logic        done;
	logic [2:0]  status;
	logic [31:0] data;
	logic [5:0]  found_position;
	logic [6:0]  count;

	list_req_t   pending[$];
	list_rsp_t   awaited_results[$];
	// Generator-side view of the list contents, used only to aim positions, keys and values and to size fill segments.
	logic [31:0] shadow_list[$];

	logic [31:0] ring [CAP];
	int          ring_head = 0;
	int          ring_count = 0;
	int          err_count = 0;

	list_req_t   cur_req;
	int          burst_left = 0;
	int          gap_left = 0;

	bounded_ordered_list_engine #(
		.CAPACITY   (CAP),
		.DATA_WIDTH (DATA_WIDTH_DEF)
	) DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.start          (start),
		.busy           (busy),
		.req_type       (req_type),
		.value          (value),
		.position       (position),
		.done           (done),
		.status         (status),
		.data           (data),
		.found_position (found_position),
		.count          (count)
	);

	initial forever #5 clk = ~clk;

	function automatic int ring_slot(int idx);
		return (ring_head + idx) % CAP;
	endfunction

	// Applies one request to the ring and returns the result it must produce.
	function automatic list_rsp_t list_result(list_req_t r);
		list_rsp_t rsp;
		int i;
		logic hit;
		rsp.sts = STS_OK;
		rsp.word = '0;
		rsp.fpos = '0;
		hit = 1'b0;
		case (r.req)
		REQ_INS_FRONT: begin
			if (ring_count >= CAP) begin
				rsp.sts = STS_FULL;
			end else begin
				ring_head = (ring_head + CAP - 1) % CAP;
				ring[ring_head] = r.val;
				ring_count++;
			end
		end
		REQ_INS_BACK: begin
			if (ring_count >= CAP) begin
				rsp.sts = STS_FULL;
			end else begin
				ring[ring_slot(ring_count)] = r.val;
				ring_count++;
			end
		end
		REQ_REM_FRONT: begin
			if (ring_count == 0) begin
				rsp.sts = STS_EMPTY;
			end else begin
				rsp.word = ring[ring_head];
				ring_head = (ring_head + 1) % CAP;
				ring_count--;
			end
		end
		REQ_REM_BACK: begin
			if (ring_count == 0) begin
				rsp.sts = STS_EMPTY;
			end else begin
				rsp.word = ring[ring_slot(ring_count - 1)];
				ring_count--;
			end
		end
		REQ_REM_AT: begin
			if (ring_count == 0) begin
				rsp.sts = STS_EMPTY;
			end else if (int'(r.pos) >= ring_count) begin
				rsp.sts = STS_BADPOS;
			end else begin
				rsp.word = ring[ring_slot(r.pos)];
				for (i = r.pos; i + 1 < ring_count; i++)
					ring[ring_slot(i)] = ring[ring_slot(i + 1)];
				ring_count--;
			end
		end
		REQ_READ_AT: begin
			if (ring_count == 0)
				rsp.sts = STS_EMPTY;
			else if (int'(r.pos) >= ring_count)
				rsp.sts = STS_BADPOS;
			else
				rsp.word = ring[ring_slot(r.pos)];
		end
		REQ_FIND: begin
			if (ring_count == 0) begin
				rsp.sts = STS_EMPTY;
			end else begin
				for (i = 0; i < ring_count; i++) begin
					if (!hit && ring[ring_slot(i)] == r.val) begin
						hit = 1'b1;
						rsp.fpos = 6'(i);
					end
				end
				if (!hit)
					rsp.sts = STS_NOTFOUND;
			end
		end
		default: ;
		endcase
		rsp.cnt = 7'(ring_count);
		return rsp;
	endfunction

	task automatic queue_request(logic [2:0] req, logic [31:0] val, logic [6:0] pos,
			logic drain);
		list_req_t r;
		r.drain = drain;
		r.req = req;
		r.val = val;
		r.pos = pos;
		pending.push_back(r);
		case (req)
		REQ_INS_FRONT: if (shadow_list.size() < CAP) shadow_list.push_front(val);
		REQ_INS_BACK: if (shadow_list.size() < CAP) shadow_list.push_back(val);
		REQ_REM_FRONT: if (shadow_list.size() != 0) void'(shadow_list.pop_front());
		REQ_REM_BACK: if (shadow_list.size() != 0) void'(shadow_list.pop_back());
		REQ_REM_AT: if (int'(pos) < shadow_list.size()) shadow_list.delete(pos);
		default: ;
		endcase
	endtask

	function automatic logic [31:0] pick_word();
		int sel;
		sel = $urandom_range(0, 9);
		if (sel == 0)
			return 32'h0;
		if (sel == 1)
			return 32'hFFFF_FFFF;
		// A small pool of values makes duplicate entries common.
		if (sel < 4)
			return {28'h0, 4'($urandom_range(0, 15))};
		if (sel < 6 && shadow_list.size() != 0)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_key();
		if (shadow_list.size() != 0 && $urandom_range(0, 4) < 3)
			return shadow_list[$urandom_range(0, shadow_list.size() - 1)];
		return pick_word();
	endfunction

	function automatic logic [6:0] pick_pos();
		int n;
		n = shadow_list.size();
		if (n != 0 && $urandom_range(0, 9) < 7)
			return 7'($urandom_range(0, n - 1));
		if ($urandom_range(0, 1) == 0)
			return 7'($urandom_range(n, 127));
		return 7'($urandom);
	endfunction

	// Sender: bursts of random length separated by random gaps.
	always @(posedge clk or negedge arst_n) begin
		logic launch;
		if (!arst_n) begin
			start <= 1'b0;
			req_type <= '0;
			value <= '0;
			position <= '0;
		end else begin
			launch = start;
			if (start && !busy) begin
				awaited_results.push_back(list_result(cur_req));
				launch = 1'b0;
			end
			if (!launch) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (pending.size() != 0 &&
						!(pending[0].drain && awaited_results.size() != 0)) begin
					cur_req = pending.pop_front();
					req_type <= cur_req.req;
					value <= cur_req.val;
					position <= cur_req.pos;
					launch = 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(0, 40);
						case ($urandom_range(0, 3))
						0: gap_left = 0;
						1: gap_left = $urandom_range(40, 90);
						default: gap_left = $urandom_range(1, 12);
						endcase
					end
				end
			end
			start <= launch;
		end
	end

	// A result beat lasts one cycle and cannot be held off, so it is taken whenever done is high.
	always @(posedge clk) begin
		list_rsp_t want;
		if (arst_n && done) begin
			if (awaited_results.size() == 0) begin
				err_count++;
				if (err_count <= MAX_REPORTS)
					$display("%0t: unexpected result: status %0d data %h found %0d count %0d",
						$realtime, status, data, found_position, count);
			end else begin
				want = awaited_results.pop_front();
				if (status !== want.sts || data !== want.word ||
						found_position !== want.fpos || count !== want.cnt) begin
					err_count++;
					if (err_count <= MAX_REPORTS) begin
						$write("%0t: mismatch: expected status %0d data %h found %0d count %0d,",
							$realtime, want.sts, want.word, want.fpos, want.cnt);
						$display(" got status %0d data %h found %0d count %0d",
							status, data, found_position, count);
					end
				end
			end
		end
	end

	initial begin
		int n_rand;
		int seg_len;
		int k;
		int r;
		mix_t mode;
		logic drain;
		logic [2:0] req;
		logic [31:0] val;
		logic [6:0] pos;

		// Requests on the empty list first, then directed inserts, reads, finds and removals.
		queue_request(REQ_REM_FRONT, 32'h0, 7'h0, 1'b0);
		queue_request(REQ_REM_BACK, 32'hFFFF_FFFF, 7'h0, 1'b0);
		queue_request(REQ_REM_AT, 32'h0, 7'h0, 1'b0);
		queue_request(REQ_READ_AT, 32'h0, 7'h7F, 1'b0);
		queue_request(REQ_FIND, 32'h0, 7'h0, 1'b0);
		queue_request(REQ_UNUSED, 32'hFFFF_FFFF, 7'h7F, 1'b0);
		queue_request(REQ_INS_BACK, 32'h0000_0000, 7'h0, 1'b0);
		queue_request(REQ_INS_FRONT, 32'hFFFF_FFFF, 7'h7F, 1'b0);
		queue_request(REQ_INS_BACK, 32'hA5A5_5A5A, 7'h0, 1'b0);
		queue_request(REQ_INS_FRONT, 32'h0000_0001, 7'h0, 1'b0);
		queue_request(REQ_READ_AT, 32'h0, 7'd0, 1'b0);
		queue_request(REQ_READ_AT, 32'h0, 7'd3, 1'b0);
		queue_request(REQ_READ_AT, 32'h0, 7'd4, 1'b0);
		queue_request(REQ_READ_AT, 32'h0, 7'h7F, 1'b0);
		queue_request(REQ_FIND, 32'h0000_0000, 7'h0, 1'b0);
		queue_request(REQ_FIND, 32'h8000_0000, 7'h0, 1'b0);
		queue_request(REQ_INS_BACK, 32'hFFFF_FFFF, 7'h0, 1'b0);
		queue_request(REQ_FIND, 32'hFFFF_FFFF, 7'h0, 1'b0);
		queue_request(REQ_REM_AT, 32'h0, 7'h7F, 1'b0);
		queue_request(REQ_REM_AT, 32'h0, 7'd1, 1'b0);
		queue_request(REQ_UNUSED, 32'h0, 7'h0, 1'b0);
		queue_request(REQ_REM_AT, 32'h0, 7'd0, 1'b0);
		queue_request(REQ_REM_BACK, 32'h0, 7'h0, 1'b0);
		queue_request(REQ_REM_FRONT, 32'h0, 7'h0, 1'b0);

		n_rand = 0;
		while (n_rand < RANDOM_ITEMS) begin
			mode = mix_t'($urandom_range(0, 3));
			seg_len = $urandom_range(20, 80);
			if (mode == MIX_FILL)
				seg_len = CAP - shadow_list.size() + $urandom_range(6, 16);
			drain = (n_rand == 0) || ($urandom_range(0, 5) == 0);
			for (k = 0; k < seg_len; k++) begin
				r = $urandom_range(0, 99);
				case (mode)
				MIX_GROW: req = (r < 65) ? ((r % 2) ? REQ_INS_FRONT : REQ_INS_BACK) :
					3'($urandom_range(0, 7));
				MIX_SHRINK: req = (r < 65) ? ((r % 3 == 0) ? REQ_REM_FRONT :
					(r % 3 == 1) ? REQ_REM_BACK : REQ_REM_AT) : 3'($urandom_range(0, 7));
				MIX_FILL: req = (r < 90) ? ((r % 2) ? REQ_INS_FRONT : REQ_INS_BACK) :
					3'($urandom_range(0, 7));
				default: req = 3'($urandom_range(0, 7));
				endcase
				val = (req == REQ_FIND) ? pick_key() : pick_word();
				pos = pick_pos();
				queue_request(req, val, pos, drain && k == 0);
				n_rand++;
			end
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		do
			@(negedge clk);
		while (pending.size() != 0 || start || awaited_results.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (err_count == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

	initial begin
		#10ms;
		$display("*** FAILED ***");
		$finish;
	end

endmodule
